// File: sv/wmva_pkg.sv
package wmva_pkg;

  // Fixed datapath widths
  localparam int MUL_W  = 32;  // shared multiplier operand width
  localparam int PROD_W = 64;  // multiplier product width
  localparam int WSUM_W = 40;  // weight sum
  localparam int SSUM_W = 56;  // signed weighted sum
  localparam int QSUM_W = 64;  // square sum
  localparam int VAR_W  = 32;  // variance, Q16.16
  localparam int DVD_W  = 64;  // divider dividend and quotient
  localparam int DEN_W  = 40;  // divider divisor

  // Operation codes of an input word
  localparam logic OP_LOG   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef logic [MUL_W-1:0]  mul_op_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [WSUM_W-1:0] wsum_t;
  typedef logic [WSUM_W:0]   wsum_x_t;
  typedef logic [SSUM_W-1:0] ssum_t;
  typedef logic [SSUM_W:0]   ssum_x_t;
  typedef logic [QSUM_W-1:0] qsum_t;
  typedef logic [QSUM_W:0]   qsum_x_t;
  typedef logic [VAR_W-1:0]  var_t;
  typedef logic [DVD_W-1:0]  dvd_t;
  typedef logic [DEN_W-1:0]  den_t;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: sv/wmva_if.sv
interface wmva_in_if #(
  parameter int X_BITS      = 16,
  parameter int WEIGHT_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [X_BITS-1:0] x_value;
  logic [WEIGHT_BITS-1:0]  weight;

  modport source (output valid, op, x_value, weight, input ready);
  modport sink   (input valid, op, x_value, weight, output ready);
endinterface

interface wmva_out_if #(
  parameter int X_BITS = 16
);
  logic                     valid;
  logic                     ready;
  wmva_pkg::wsum_t          weight_total;
  logic signed [X_BITS-1:0] mean;
  wmva_pkg::var_t           variance;
  logic signed [X_BITS-1:0] min_x;
  logic signed [X_BITS-1:0] max_x;
  logic                     has_data;

  modport source (output valid, weight_total, mean, variance, min_x, max_x, has_data,
                  input ready);
  modport sink   (input valid, weight_total, mean, variance, min_x, max_x, has_data,
                  output ready);
endinterface

// File: sv/wmva_mul.sv
module wmva_mul (
  input  logic              clk,
  input  wmva_pkg::mul_op_t a,
  input  wmva_pkg::mul_op_t b,
  output wmva_pkg::prod_t   p_r
);

  // Register the full unsigned product
  always_ff @(posedge clk) begin
    p_r <= wmva_pkg::prod_t'(a) * wmva_pkg::prod_t'(b);
  end

endmodule

// File: sv/wmva_div.sv
module wmva_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  wmva_pkg::dvd_t      dividend,
  input  wmva_pkg::den_t      divisor,
  output wmva_pkg::div_stat_t stat,
  output wmva_pkg::dvd_t      quotient
);

  localparam int CNT_W = $clog2(wmva_pkg::DVD_W);
  typedef logic [CNT_W-1:0] cnt_t;

  wmva_pkg::dvd_t        quo_r;
  wmva_pkg::den_t        rem_r;
  wmva_pkg::den_t        den_r;
  cnt_t                  cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [wmva_pkg::DEN_W:0] shifted;
  logic [wmva_pkg::DEN_W:0] diff;
  logic                  q_bit;
  wmva_pkg::den_t        rem_nxt;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem_r, quo_r[wmva_pkg::DVD_W-1]};
    diff    = shifted - {1'b0, den_r};
    q_bit   = ~diff[wmva_pkg::DEN_W];
    rem_nxt = q_bit ? diff[wmva_pkg::DEN_W-1:0] : shifted[wmva_pkg::DEN_W-1:0];
  end

  // Step counter and status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == cnt_t'(wmva_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Shift quotient bits into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[wmva_pkg::DVD_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// File: sv/weighted_mean_variance_accumulator_core.sv
// Weighted running mean and variance. Each input word either clears the
// block (op = 1) or logs a signed Q8.8 value with an unsigned integer weight,
// and each word yields one result word: weight total, weighted mean (Q8.8),
// sample variance (Q16.16, clamped at zero and saturated), smallest and
// largest value and a data flag, all taken after the update. One word is
// worked on at a time and in_ch.ready is low until its result is in the
// output register; a finished result may wait there while the next word is
// taken. Once the weight total exceeds one, a log word runs a 64-step
// radix-2 divider twice (mean, then variance) behind six passes through
// one shared 32x32 multiplier. A word that skips a division finishes
// sooner; a clear passes through the S_MEAN, S_VM1 and S_OUT states on its
// way to the output register.
module weighted_mean_variance_accumulator_core #(
  parameter int X_BITS      = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  wmva_in_if.sink     in_ch,
  wmva_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_MWX, S_MX2, S_MSLO, S_MSHI, S_ACC, S_SQ, S_MEAN, S_MDIV,
    S_VM1, S_VM2, S_VM3, S_VSUB, S_VDIV, S_OUT
  } state_t;

  localparam wmva_pkg::dvd_t X_HALF = wmva_pkg::dvd_t'(1) << (X_BITS - 1);

  state_t                  state_r;

  // Accumulated state
  wmva_pkg::wsum_t         weight_sum_r;
  wmva_pkg::ssum_t         weighted_sum_r;
  wmva_pkg::qsum_t         square_sum_r;
  logic [X_BITS-1:0]       smallest_r;
  logic [X_BITS-1:0]       largest_r;
  logic                    seen_r;

  // Working registers
  logic [X_BITS-1:0]       x_r;
  logic [WEIGHT_BITS-1:0]  w_r;
  wmva_pkg::ssum_t         wx_mag_r;
  wmva_pkg::mul_op_t       x2_hi_r;
  wmva_pkg::prod_t         part_lo_r;
  wmva_pkg::qsum_t         hl_r;
  logic                    hl_ovf_r;
  logic [X_BITS-1:0]       mean_r;
  wmva_pkg::mul_op_t       mean_mag_r;
  wmva_pkg::var_t          var_r;

  // Output register
  logic                    out_valid_r;
  wmva_pkg::wsum_t         o_wsum_r;
  logic [X_BITS-1:0]       o_mean_r;
  wmva_pkg::var_t          o_var_r;
  logic [X_BITS-1:0]       o_min_r;
  logic [X_BITS-1:0]       o_max_r;
  logic                    o_seen_r;

  // Shared units
  wmva_pkg::mul_op_t       mul_a;
  wmva_pkg::mul_op_t       mul_b;
  wmva_pkg::prod_t         p_r;
  logic                    div_start;
  wmva_pkg::dvd_t          div_dvd;
  wmva_pkg::den_t          div_den;
  wmva_pkg::div_stat_t     div_stat;
  wmva_pkg::dvd_t          div_quo;

  // Combinational helpers
  logic                    x_neg;
  logic [X_BITS-1:0]       x_abs;
  wmva_pkg::mul_op_t       x_abs_op;
  wmva_pkg::mul_op_t       w_op;
  wmva_pkg::ssum_t         ssum_mag;
  wmva_pkg::wsum_x_t       wsum_sum;
  wmva_pkg::wsum_t         wsum_nxt;
  wmva_pkg::ssum_x_t       wx_ext;
  wmva_pkg::ssum_x_t       ssum_sum;
  wmva_pkg::ssum_t         ssum_nxt;
  wmva_pkg::ssum_t         ssum_min;
  wmva_pkg::qsum_x_t       hl_sum;
  logic                    hl_ovf;
  wmva_pkg::qsum_x_t       qsum_sum;
  wmva_pkg::qsum_t         qsum_nxt;
  wmva_pkg::qsum_x_t       num_diff;
  logic                    num_bad;
  logic                    ws_zero;
  logic                    ws_le1;
  logic                    mean_neg;
  wmva_pkg::dvd_t          mean_lim;
  wmva_pkg::dvd_t          mean_mag;
  logic [X_BITS-1:0]       mean_nxt;
  wmva_pkg::var_t          var_nxt;

  wmva_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  wmva_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_den),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Magnitudes of the logged value and the weighted sum
  always_comb begin
    x_neg    = x_r[X_BITS-1];
    x_abs    = x_neg ? (~x_r + 1'b1) : x_r;
    x_abs_op = wmva_pkg::mul_op_t'(x_abs);
    w_op     = wmva_pkg::mul_op_t'(w_r);
    ssum_mag = weighted_sum_r[wmva_pkg::SSUM_W-1] ? (~weighted_sum_r + 1'b1)
                                                  : weighted_sum_r;
    ws_zero  = (weight_sum_r == '0);
    ws_le1   = (weight_sum_r[wmva_pkg::WSUM_W-1:1] == '0);
  end

  // Steer the shared multiplier
  always_comb begin
    case (state_r)
      S_MWX:   begin mul_a = x_abs_op;                          mul_b = w_op;       end
      S_MX2:   begin mul_a = x_abs_op;                          mul_b = x_abs_op;   end
      S_MSLO:  begin mul_a = p_r[wmva_pkg::MUL_W-1:0];          mul_b = w_op;       end
      S_MSHI:  begin mul_a = x2_hi_r;                           mul_b = w_op;       end
      S_VM1:   begin mul_a = ssum_mag[wmva_pkg::MUL_W-1:0];     mul_b = mean_mag_r; end
      S_VM2:   begin
        mul_a = wmva_pkg::mul_op_t'(ssum_mag[wmva_pkg::SSUM_W-1:wmva_pkg::MUL_W]);
        mul_b = mean_mag_r;
      end
      default: begin mul_a = '0;                                mul_b = '0;         end
    endcase
  end

  // Saturating accumulator updates
  always_comb begin
    wsum_sum = wmva_pkg::wsum_x_t'(weight_sum_r) + wmva_pkg::wsum_x_t'(w_r);
    wsum_nxt = wsum_sum[wmva_pkg::WSUM_W] ? '1 : wsum_sum[wmva_pkg::WSUM_W-1:0];

    wx_ext   = x_neg ? (~wmva_pkg::ssum_x_t'(wx_mag_r) + 1'b1)
                     : wmva_pkg::ssum_x_t'(wx_mag_r);
    ssum_sum = {weighted_sum_r[wmva_pkg::SSUM_W-1], weighted_sum_r} + wx_ext;
    ssum_min = wmva_pkg::ssum_t'(1) << (wmva_pkg::SSUM_W - 1);
    if (ssum_sum[wmva_pkg::SSUM_W] != ssum_sum[wmva_pkg::SSUM_W-1]) begin
      ssum_nxt = ssum_sum[wmva_pkg::SSUM_W] ? ssum_min : ~ssum_min;
    end else begin
      ssum_nxt = ssum_sum[wmva_pkg::SSUM_W-1:0];
    end

    // Join the high and low partial products of a 64-bit product
    hl_sum = wmva_pkg::qsum_x_t'({p_r[wmva_pkg::MUL_W-1:0], wmva_pkg::mul_op_t'(0)})
           + wmva_pkg::qsum_x_t'(part_lo_r);
    hl_ovf = (|p_r[wmva_pkg::PROD_W-1:wmva_pkg::MUL_W]) | hl_sum[wmva_pkg::QSUM_W];

    qsum_sum = wmva_pkg::qsum_x_t'(square_sum_r) + wmva_pkg::qsum_x_t'(hl_r);
    qsum_nxt = (hl_ovf_r | qsum_sum[wmva_pkg::QSUM_W]) ? '1
                                                       : qsum_sum[wmva_pkg::QSUM_W-1:0];

    // Variance numerator; drop it when not positive
    num_diff = wmva_pkg::qsum_x_t'(square_sum_r) - wmva_pkg::qsum_x_t'(hl_r);
    num_bad  = hl_ovf_r | num_diff[wmva_pkg::QSUM_W] | (num_diff == '0);
  end

  // Drive the divider for mean and variance
  always_comb begin
    div_start = 1'b0;
    div_dvd   = wmva_pkg::dvd_t'(ssum_mag);
    div_den   = weight_sum_r;
    if (state_r == S_MEAN) begin
      div_start = ~ws_zero;
    end else if (state_r == S_VSUB) begin
      div_start = ~num_bad;
      div_dvd   = num_diff[wmva_pkg::DVD_W-1:0];
      div_den   = weight_sum_r - 1'b1;
    end
  end

  // Saturate the quotients
  always_comb begin
    mean_neg = weighted_sum_r[wmva_pkg::SSUM_W-1];
    mean_lim = mean_neg ? X_HALF : (X_HALF - 1'b1);
    mean_mag = (div_quo > mean_lim) ? mean_lim : div_quo;
    mean_nxt = mean_neg ? (~mean_mag[X_BITS-1:0] + 1'b1) : mean_mag[X_BITS-1:0];
    var_nxt  = (|div_quo[wmva_pkg::DVD_W-1:wmva_pkg::VAR_W]) ? '1
                                                             : div_quo[wmva_pkg::VAR_W-1:0];
  end

  // Sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      weight_sum_r   <= '0;
      weighted_sum_r <= '0;
      square_sum_r   <= '0;
      smallest_r     <= '0;
      largest_r      <= '0;
      seen_r         <= 1'b0;
    end else begin
      // Drop the taken result unless a new one is loaded this cycle
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.op == wmva_pkg::OP_CLEAR) begin
              weight_sum_r   <= '0;
              weighted_sum_r <= '0;
              square_sum_r   <= '0;
              smallest_r     <= '0;
              largest_r      <= '0;
              seen_r         <= 1'b0;
              state_r        <= S_MEAN;
            end else begin
              x_r     <= in_ch.x_value;
              w_r     <= in_ch.weight;
              state_r <= S_MWX;
            end
          end
        end
        S_MWX: state_r <= S_MX2;
        S_MX2: begin
          wx_mag_r <= p_r[wmva_pkg::SSUM_W-1:0];
          state_r  <= S_MSLO;
        end
        S_MSLO: begin
          x2_hi_r <= p_r[wmva_pkg::PROD_W-1:wmva_pkg::MUL_W];
          state_r <= S_MSHI;
        end
        S_MSHI: begin
          part_lo_r <= p_r;
          state_r   <= S_ACC;
        end
        S_ACC: begin
          weight_sum_r   <= wsum_nxt;
          weighted_sum_r <= ssum_nxt;
          hl_r           <= hl_sum[wmva_pkg::QSUM_W-1:0];
          hl_ovf_r       <= hl_ovf;
          if (!seen_r) begin
            smallest_r <= x_r;
            largest_r  <= x_r;
            seen_r     <= 1'b1;
          end else begin
            if ($signed(x_r) > $signed(largest_r))  largest_r  <= x_r;
            if ($signed(x_r) < $signed(smallest_r)) smallest_r <= x_r;
          end
          state_r <= S_SQ;
        end
        S_SQ: begin
          square_sum_r <= qsum_nxt;
          state_r      <= S_MEAN;
        end
        S_MEAN: begin
          if (ws_zero) begin
            mean_r     <= '0;
            mean_mag_r <= '0;
            state_r    <= S_VM1;
          end else begin
            state_r <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (div_stat.done) begin
            mean_r     <= mean_nxt;
            mean_mag_r <= mean_mag[wmva_pkg::MUL_W-1:0];
            state_r    <= S_VM1;
          end
        end
        S_VM1: begin
          if (ws_le1) begin
            var_r   <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_VM2;
          end
        end
        S_VM2: begin
          part_lo_r <= p_r;
          state_r   <= S_VM3;
        end
        S_VM3: begin
          hl_r     <= hl_sum[wmva_pkg::QSUM_W-1:0];
          hl_ovf_r <= hl_ovf;
          state_r  <= S_VSUB;
        end
        S_VSUB: begin
          if (num_bad) begin
            var_r   <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (div_stat.done) begin
            var_r   <= var_nxt;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // Load the result once the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            o_wsum_r    <= weight_sum_r;
            o_mean_r    <= mean_r;
            o_var_r     <= var_r;
            o_min_r     <= smallest_r;
            o_max_r     <= largest_r;
            o_seen_r    <= seen_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = rst_n && (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.weight_total = o_wsum_r;
  assign out_ch.mean         = o_mean_r;
  assign out_ch.variance     = o_var_r;
  assign out_ch.min_x        = o_min_r;
  assign out_ch.max_x        = o_max_r;
  assign out_ch.has_data     = o_seen_r;

  // The divider is never restarted mid-run
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A weight total of at most one gives no variance, and zero gives no mean; only the zero case is checked here
  a_small_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.weight_total == '0) |->
      (out_ch.mean == '0) && (out_ch.variance == '0))
    else $error("nonzero mean or variance with zero weight total");

  // Extremes stay ordered whenever data was logged
  a_extremes_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.has_data |-> (out_ch.min_x <= out_ch.max_x))
    else $error("smallest value above largest value");

endmodule

// File: tb/tb_weighted_mean_variance_accumulator_core.sv
`timescale 1ns / 100ps

module tb_weighted_mean_variance_accumulator_core;

  typedef struct packed {
    logic               op;
    logic signed [15:0] x_value;
    logic [15:0]        weight;
  } word_t;

  typedef struct packed {
    wmva_pkg::wsum_t    weight_total;
    logic signed [15:0] mean;
    wmva_pkg::var_t     variance;
    logic signed [15:0] min_x;
    logic signed [15:0] max_x;
    logic               has_data;
  } stats_t;

  localparam longint          WX_MAX    = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint          WX_MIN    = -WX_MAX - 1;
  localparam longint unsigned WEIGHT_SAT = 64'h0000_00FF_FFFF_FFFF;
  localparam longint unsigned VAR_SAT    = 64'h0000_0000_FFFF_FFFF;
  localparam int              DRAIN_CYCLES = 150;
  localparam int              HOLD_CYCLES  = 1000;

  logic clk;
  logic rst_n;

  wmva_in_if  #(.X_BITS(16), .WEIGHT_BITS(16)) in_bus ();
  wmva_out_if #(.X_BITS(16))                   out_bus ();

  weighted_mean_variance_accumulator_core #(
    .X_BITS(16),
    .WEIGHT_BITS(16)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  word_t  pending_words[$];
  stats_t expected_stats[$];

  // Running statistics mirrored from the accepted words
  longint unsigned    run_weight = 0;
  longint             run_wx     = 0;
  longint unsigned    run_sq     = 0;
  logic signed [15:0] run_lo     = '0;
  logic signed [15:0] run_hi     = '0;
  logic               run_seen   = 1'b0;

  int  word_total   = 0;
  int  words_taken  = 0;
  int  results_seen = 0;
  int  fail_count   = 0;
  int  in_gap_left  = 0;
  int  out_stall_left = 0;
  logic quiet_tail  = 1'b0;
  logic hold_off;
  word_t  next_word;
  stats_t want;

  // Fold one accepted word into the running statistics and return the result
  function automatic stats_t fold_word(input word_t wd);
    stats_t           r;
    longint           xs;
    longint           wx;
    longint           total;
    longint           mean_l;
    longint unsigned  w;
    longint unsigned  ax;
    longint unsigned  x2;
    longint unsigned  mag;
    longint unsigned  q;
    longint unsigned  m;
    longint unsigned  v;
    logic [64:0]      sq_ext;
    logic [127:0]     prod;
    if (wd.op == wmva_pkg::OP_CLEAR) begin
      run_weight = 0;
      run_wx     = 0;
      run_sq     = 0;
      run_lo     = '0;
      run_hi     = '0;
      run_seen   = 1'b0;
    end else begin
      xs = wd.x_value;
      w  = wd.weight;
      ax = (xs < 0) ? -xs : xs;
      x2 = ax * ax;
      wx = $signed(w) * xs;

      run_weight = run_weight + w;
      if (run_weight > WEIGHT_SAT) run_weight = WEIGHT_SAT;

      total = run_wx + wx;
      if (total > WX_MAX) total = WX_MAX;
      if (total < WX_MIN) total = WX_MIN;
      run_wx = total;

      sq_ext = {1'b0, run_sq} + {1'b0, w * x2};
      run_sq = sq_ext[64] ? '1 : sq_ext[63:0];

      // First log after a clear sets both extremes
      if (!run_seen) begin
        run_lo   = wd.x_value;
        run_hi   = wd.x_value;
        run_seen = 1'b1;
      end else begin
        if (wd.x_value > run_hi) run_hi = wd.x_value;
        if (wd.x_value < run_lo) run_lo = wd.x_value;
      end
    end

    // Mean truncates toward zero and saturates to the Q8.8 range
    mag = (run_wx < 0) ? -run_wx : run_wx;
    if (run_weight == 0) begin
      mean_l = 0;
    end else begin
      q = mag / run_weight;
      if (run_wx < 0) begin
        if (q > 32768) q = 32768;
        mean_l = -$signed(q);
      end else begin
        if (q > 32767) q = 32767;
        mean_l = $signed(q);
      end
    end

    // Variance clamps at zero when the product overflows or covers the square sum
    v = 0;
    if (run_weight > 1) begin
      m    = (mean_l < 0) ? -mean_l : mean_l;
      prod = 128'(mag) * 128'(m);
      if (prod[127:64] == '0 && prod[63:0] < run_sq) begin
        v = (run_sq - prod[63:0]) / (run_weight - 1);
        if (v > VAR_SAT) v = VAR_SAT;
      end
    end

    r.weight_total = run_weight[39:0];
    r.mean         = mean_l[15:0];
    r.variance     = v[31:0];
    r.min_x        = run_lo;
    r.max_x        = run_hi;
    r.has_data     = run_seen;
    return r;
  endfunction

  function automatic void queue_word(input logic op, input logic [15:0] x,
                                     input logic [15:0] w);
    word_t wd;
    wd.op      = op;
    wd.x_value = x;
    wd.weight  = w;
    pending_words.push_back(wd);
    word_total++;
  endfunction

  function automatic logic [15:0] pick_x(input logic [15:0] center, input int spread);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      case ($urandom_range(0, 3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end else if (sel < 10) begin
      return 16'(int'($signed(center)) + $urandom_range(0, 2 * spread) - spread);
    end
    return 16'($urandom());
  endfunction

  function automatic logic [15:0] pick_weight();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 5) return 16'($urandom_range(0, 3));
    if (sel == 5) return 16'hFFFF;
    if (sel < 9) return 16'($urandom_range(0, 255));
    return 16'($urandom());
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Build the stimulus: directed corners first, then random runs between clears
  initial begin
    int          left;
    int          run_len;
    int          spread;
    logic [15:0] center;
    queue_word(wmva_pkg::OP_LOG,   16'h0000, 16'h0000);  // zero weight as first log
    queue_word(wmva_pkg::OP_LOG,   16'h8000, 16'h0000);  // zero weight still moves extremes
    queue_word(wmva_pkg::OP_CLEAR, 16'h1234, 16'h5678);
    queue_word(wmva_pkg::OP_LOG,   16'h7FFF, 16'h0001);  // weight total of one
    queue_word(wmva_pkg::OP_LOG,   16'h8000, 16'hFFFF);
    queue_word(wmva_pkg::OP_LOG,   16'h7FFF, 16'hFFFF);
    queue_word(wmva_pkg::OP_LOG,   16'h5555, 16'hAAAA);
    queue_word(wmva_pkg::OP_LOG,   16'hAAAA, 16'h5555);
    queue_word(wmva_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
    queue_word(wmva_pkg::OP_LOG,   16'h0100, 16'h0003);  // identical values: numerator hits zero
    queue_word(wmva_pkg::OP_LOG,   16'h0100, 16'h0003);
    queue_word(wmva_pkg::OP_LOG,   16'h0100, 16'h0003);
    queue_word(wmva_pkg::OP_LOG,   16'hFFFF, 16'h0001);
    queue_word(wmva_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    queue_word(wmva_pkg::OP_CLEAR, 16'h8000, 16'h0001);
    queue_word(wmva_pkg::OP_LOG,   16'h8000, 16'hFFFF);
    queue_word(wmva_pkg::OP_LOG,   16'h8000, 16'hFFFF);
    queue_word(wmva_pkg::OP_LOG,   16'h8000, 16'hFFFF);
    queue_word(wmva_pkg::OP_LOG,   16'h8001, 16'h0002);
    queue_word(wmva_pkg::OP_LOG,   16'h0001, 16'h0000);
    queue_word(wmva_pkg::OP_CLEAR, 16'h0000, 16'h0000);

    left = 930;
    while (left > 0) begin
      run_len = $urandom_range(5, 60);
      center  = 16'($urandom());
      spread  = 1 << $urandom_range(0, 12);
      queue_word(wmva_pkg::OP_CLEAR, 16'($urandom()), 16'($urandom()));
      for (int i = 0; i < run_len; i++) begin
        queue_word(wmva_pkg::OP_LOG, pick_x(center, spread), pick_weight());
      end
      left -= run_len + 1;
    end
  end

  // Reset, drain and verdict
  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!(words_taken == word_total && expected_stats.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("weighted_mean_variance_accumulator_core verification clean");
    end else begin
      $display("weighted_mean_variance_accumulator_core verification failed");
    end
    $finish;
  end

  // Hold off the result side for a long stretch so the input stalls
  initial begin
    hold_off <= 1'b0;
    wait (results_seen >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Drive input words, predicting each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_bus.valid) begin
        expected_stats.push_back(fold_word('{op: in_bus.op, x_value: in_bus.x_value,
                                             weight: in_bus.weight}));
        words_taken <= words_taken + 1;
      end
      quiet_tail <= (pending_words.size() < 60);
      if (in_gap_left > 0) begin
        in_gap_left  <= in_gap_left - 1;
        in_bus.valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        in_gap_left  <= $urandom_range(0, 9);
        in_bus.valid <= 1'b0;
      end else begin
        next_word      = pending_words.pop_front();
        in_bus.op      <= next_word.op;
        in_bus.x_value <= next_word.x_value;
        in_bus.weight  <= next_word.weight;
        in_bus.valid   <= 1'b1;
      end
    end
  end

  // Check result words against the oldest prediction and pace ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen <= results_seen + 1;
        if (expected_stats.size() == 0) begin
          $error("result word arrived with no prediction pending");
          fail_count++;
        end else begin
          want = expected_stats.pop_front();
          if (out_bus.weight_total !== want.weight_total) begin
            $error("weight_total: expected %0d, actual %0d",
                   want.weight_total, out_bus.weight_total);
            fail_count++;
          end
          if (out_bus.mean !== want.mean) begin
            $error("mean: expected %0d, actual %0d", want.mean, out_bus.mean);
            fail_count++;
          end
          if (out_bus.variance !== want.variance) begin
            $error("variance: expected %0d, actual %0d", want.variance, out_bus.variance);
            fail_count++;
          end
          if (out_bus.min_x !== want.min_x) begin
            $error("min_x: expected %0d, actual %0d", want.min_x, out_bus.min_x);
            fail_count++;
          end
          if (out_bus.max_x !== want.max_x) begin
            $error("max_x: expected %0d, actual %0d", want.max_x, out_bus.max_x);
            fail_count++;
          end
          if (out_bus.has_data !== want.has_data) begin
            $error("has_data: expected %0d, actual %0d", want.has_data, out_bus.has_data);
            fail_count++;
          end
        end
      end
      if (hold_off) begin
        out_bus.ready <= 1'b0;
      end else if (out_stall_left > 0) begin
        out_stall_left <= out_stall_left - 1;
        out_bus.ready  <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_stall_left <= $urandom_range(0, 9);
        out_bus.ready  <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("weighted_mean_variance_accumulator_core verification failed");
    $finish;
  end

endmodule
